// File: hw/rtl/cdpd_pkg.sv
package cdpd_pkg;

  // field widths
  localparam int ReqW    = 2;
  localparam int SampleW = 10;
  localparam int StampW  = 32;
  localparam int DebW    = 16;
  localparam int ThrW    = 10;
  localparam int SumW    = 15;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 16;

  // defaults
  localparam int CalSamplesDef = 30;
  localparam logic [DebW-1:0] DebounceRst  = DebW'(100);
  localparam logic [ThrW-1:0] ThresholdRst = ThrW'(30);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 1'b1;

  // request codes
  typedef enum logic [ReqW-1:0] {
    REQ_CAL_START  = 2'd0,
    REQ_CAL_SAMPLE = 2'd1,
    REQ_SENSOR     = 2'd2,
    REQ_READ_FLAGS = 2'd3
  } req_type_t;

endpackage

// File: hw/rtl/calibrated_debounced_presence_detector.sv
// path: an accepted word is held in the input register, then written to the result register, which drives out_valid
// throughput: one word per cycle; the input register feeds the state update and result
//   register directly, so input and output stall only on out_ready
// reset: synchronous active-low rst_n clears all detector state and valid bits and
//   loads debounce_ms = 100 and threshold = 30; no clearing pass is needed
module calibrated_debounced_presence_detector #(
  parameter int CAL_SAMPLES = cdpd_pkg::CalSamplesDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cdpd_pkg::ReqW-1:0]        in_req_type,
  input  logic [cdpd_pkg::SampleW-1:0]     in_sample_value,
  input  logic [cdpd_pkg::StampW-1:0]      in_now_ms,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_detected,
  output logic                             out_lost,
  output logic                             out_present,
  output logic [cdpd_pkg::SampleW-1:0]     out_baseline,
  output logic                             out_calibrated,
  // configuration port
  input  logic                             cfg_we,
  input  logic [cdpd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [cdpd_pkg::CfgW-1:0]        cfg_wdata
);

  localparam int SumW     = cdpd_pkg::SumW;
  localparam int BaseW    = cdpd_pkg::SampleW;
  localparam int CntW     = $clog2(CAL_SAMPLES + 1);
  // exact reciprocal for a SumW-bit dividend
  localparam int DivShift = SumW + $clog2(CAL_SAMPLES);
  localparam int MulW     = DivShift + 1;
  localparam int ProdW    = SumW + MulW;
  localparam logic [MulW-1:0] DivMul =
    MulW'(((64'd1 << DivShift) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam logic [CntW-1:0] CalLast = CntW'(CAL_SAMPLES);

  // configuration registers
  logic [cdpd_pkg::DebW-1:0] debounce_r;
  logic [cdpd_pkg::ThrW-1:0] threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= cdpd_pkg::DebounceRst;
      threshold_r <= cdpd_pkg::ThresholdRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdpd_pkg::CFG_DEBOUNCE:  debounce_r  <= cfg_wdata[cdpd_pkg::DebW-1:0];
        cdpd_pkg::CFG_THRESHOLD: threshold_r <= cfg_wdata[cdpd_pkg::ThrW-1:0];
      endcase
    end
  end

  // handshake: input register then result register
  logic s1_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic fire;

  assign out_adv  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;

  // input register
  cdpd_pkg::req_type_t          s1_req_r;
  logic [BaseW-1:0]             s1_sample_r;
  logic [cdpd_pkg::StampW-1:0]  s1_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r    <= cdpd_pkg::req_type_t'(in_req_type);
      s1_sample_r <= in_sample_value;
      s1_now_r    <= in_now_ms;
    end
  end

  // detector state
  logic [BaseW-1:0]            baseline_r, baseline_nxt;
  logic [SumW-1:0]             cal_sum_r, cal_sum_nxt;
  logic [CntW-1:0]             cal_count_r, cal_count_nxt;
  logic                        raw_r, raw_nxt;
  logic                        prev_raw_r, prev_raw_nxt;
  logic                        deb_r, deb_nxt;
  logic                        tmr_run_r, tmr_run_nxt;
  logic [cdpd_pkg::StampW-1:0] tmr_start_r, tmr_start_nxt;
  logic                        det_flag_r, det_flag_nxt;
  logic                        lost_flag_r, lost_flag_nxt;
  logic                        rd_det, rd_lost;

  // calibration datapath: running sum and mean by reciprocal multiply
  logic [SumW-1:0]  sum_inc;
  logic [CntW-1:0]  count_inc;
  logic [ProdW-1:0] mean_prod;
  logic [BaseW-1:0] mean;

  assign sum_inc   = cal_sum_r + SumW'(s1_sample_r);
  assign count_inc = cal_count_r + 1'b1;
  assign mean_prod = ProdW'(sum_inc) * ProdW'(DivMul);
  assign mean      = mean_prod[DivShift +: BaseW];

  // sensor datapath: deviation compare and debounce timer
  logic [BaseW-1:0]            diff;
  logic                        beam_cut;
  logic [cdpd_pkg::StampW-1:0] elapsed;
  logic                        settled;

  assign diff     = (s1_sample_r > baseline_r) ? (s1_sample_r - baseline_r)
                                               : (baseline_r - s1_sample_r);
  assign beam_cut = diff > threshold_r;
  assign elapsed  = s1_now_r - tmr_start_r;
  assign settled  = elapsed > cdpd_pkg::StampW'(debounce_r);

  // next state
  always_comb begin
    baseline_nxt  = baseline_r;
    cal_sum_nxt   = cal_sum_r;
    cal_count_nxt = cal_count_r;
    raw_nxt       = raw_r;
    prev_raw_nxt  = prev_raw_r;
    deb_nxt       = deb_r;
    tmr_run_nxt   = tmr_run_r;
    tmr_start_nxt = tmr_start_r;
    det_flag_nxt  = det_flag_r;
    lost_flag_nxt = lost_flag_r;
    rd_det        = 1'b0;
    rd_lost       = 1'b0;
    if (fire) begin
      unique case (s1_req_r)
        cdpd_pkg::REQ_CAL_START: begin
          baseline_nxt  = '0;
          cal_sum_nxt   = '0;
          cal_count_nxt = '0;
          raw_nxt       = 1'b0;
          prev_raw_nxt  = 1'b0;
          deb_nxt       = 1'b0;
          tmr_run_nxt   = 1'b0;
          tmr_start_nxt = '0;
          det_flag_nxt  = 1'b0;
          lost_flag_nxt = 1'b0;
        end
        cdpd_pkg::REQ_CAL_SAMPLE: begin
          if (cal_count_r < CalLast) begin
            cal_sum_nxt   = sum_inc;
            cal_count_nxt = count_inc;
            if (count_inc == CalLast) begin
              baseline_nxt = mean;
            end
          end
        end
        cdpd_pkg::REQ_SENSOR: begin
          if (baseline_r != '0) begin
            raw_nxt = beam_cut;
            if (beam_cut != prev_raw_r) begin
              tmr_start_nxt = s1_now_r;
              tmr_run_nxt   = 1'b1;
            end else if (tmr_run_r && settled) begin
              tmr_run_nxt = 1'b0;
              if (deb_r != beam_cut) begin
                det_flag_nxt  = beam_cut;
                lost_flag_nxt = !beam_cut;
              end
              deb_nxt = beam_cut;
            end
            prev_raw_nxt = beam_cut;
          end
        end
        cdpd_pkg::REQ_READ_FLAGS: begin
          rd_det        = det_flag_r;
          rd_lost       = lost_flag_r;
          det_flag_nxt  = 1'b0;
          lost_flag_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r  <= '0;
      cal_sum_r   <= '0;
      cal_count_r <= '0;
      raw_r       <= 1'b0;
      prev_raw_r  <= 1'b0;
      deb_r       <= 1'b0;
      tmr_run_r   <= 1'b0;
      tmr_start_r <= '0;
      det_flag_r  <= 1'b0;
      lost_flag_r <= 1'b0;
    end else begin
      baseline_r  <= baseline_nxt;
      cal_sum_r   <= cal_sum_nxt;
      cal_count_r <= cal_count_nxt;
      raw_r       <= raw_nxt;
      prev_raw_r  <= prev_raw_nxt;
      deb_r       <= deb_nxt;
      tmr_run_r   <= tmr_run_nxt;
      tmr_start_r <= tmr_start_nxt;
      det_flag_r  <= det_flag_nxt;
      lost_flag_r <= lost_flag_nxt;
    end
  end

  // result register
  logic             out_det_r, out_lost_r, out_present_r, out_cal_r;
  logic [BaseW-1:0] out_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_det_r     <= rd_det;
      out_lost_r    <= rd_lost;
      out_present_r <= deb_nxt;
      out_base_r    <= baseline_nxt;
      out_cal_r     <= baseline_nxt != '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_detected   = out_det_r;
  assign out_lost       = out_lost_r;
  assign out_present    = out_present_r;
  assign out_baseline   = out_base_r;
  assign out_calibrated = out_cal_r;

  // checks
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(det_flag_r && lost_flag_r))
    else $error("detect and lost flags both set");

  a_idle_uncalibrated: assert property (@(posedge clk) disable iff (!rst_n)
    (baseline_r == '0) |-> (!raw_r && !deb_r && !tmr_run_r))
    else $error("sensor state moved without a baseline");

  a_cal_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cal_count_r <= CalLast)
    else $error("calibration count overran");

  a_result_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cal_r == (out_base_r != '0)))
    else $error("calibrated flag disagrees with baseline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> (s1_valid_r && $stable(s1_sample_r)
                                   && $stable(s1_now_r) && $stable(s1_req_r)))
    else $error("input register changed while stalled");

endmodule
